/* rtl/pid_controller_clamped_defines.svh */
// Assertion macros shared by the RTL files of the clamped PID controller.
// Included by bare file name from any module that carries checks.
`ifndef PID_CONTROLLER_CLAMPED_DEFINES_SVH
`define PID_CONTROLLER_CLAMPED_DEFINES_SVH

// Same-cycle implication under reset.
`define PCC_ASSERT_NOW(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("pcc: same-cycle check failed");

// Next-cycle implication under reset.
`define PCC_ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("pcc: next-cycle check failed");

`endif

/* rtl/pcc_pkg.sv */
// Package of the clamped PID controller: register indexes, the register
// file struct and the symmetric clamp function. No dependencies.
`default_nettype none

package pcc_pkg;

	localparam logic [2:0] REG_GAIN_P    = 3'd0;
	localparam logic [2:0] REG_GAIN_I    = 3'd1;
	localparam logic [2:0] REG_GAIN_D    = 3'd2;
	localparam logic [2:0] REG_INT_LIM   = 3'd3;
	localparam logic [2:0] REG_DER_LIM   = 3'd4;
	localparam logic [2:0] REG_OUT_LIM   = 3'd5;
	localparam logic [2:0] REG_PERIOD    = 3'd6;
	localparam logic [2:0] REG_RATE      = 3'd7;

	localparam logic [16:0] PERIOD_RESET = 17'h10000;
	localparam logic [23:0] RATE_RESET   = 24'd1;

	typedef struct packed {
		logic signed [31:0] gain_proportional;
		logic signed [31:0] gain_integral;
		logic signed [31:0] gain_derivative;
		logic [30:0]        integral_limit;
		logic [30:0]        derivative_limit;
		logic [30:0]        output_limit;
		logic [16:0]        sample_period;
		logic [23:0]        sample_rate;
	} cfg_t;

	function automatic logic signed [31:0] clamp_sym(input logic signed [57:0] v,
		input logic [30:0] lim);
		logic signed [57:0] hi;
		logic signed [57:0] lo;
		hi = $signed({27'b0, lim});
		lo = -hi;
		if (v > hi) begin
			return hi[31:0];
		end else if (v < lo) begin
			return lo[31:0];
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

`default_nettype wire

/* rtl/pcc_cfg.sv */
// Configuration register file of the clamped PID controller.
// Depends on pcc_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module pcc_cfg (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	output pcc_pkg::cfg_t     regs
);

	pcc_pkg::cfg_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.gain_proportional <= '0;
			regs_q.gain_integral     <= '0;
			regs_q.gain_derivative   <= '0;
			regs_q.integral_limit    <= '0;
			regs_q.derivative_limit  <= '0;
			regs_q.output_limit      <= '0;
			regs_q.sample_period     <= pcc_pkg::PERIOD_RESET;
			regs_q.sample_rate       <= pcc_pkg::RATE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pcc_pkg::REG_GAIN_P:  regs_q.gain_proportional <= cfg_data;
				pcc_pkg::REG_GAIN_I:  regs_q.gain_integral     <= cfg_data;
				pcc_pkg::REG_GAIN_D:  regs_q.gain_derivative   <= cfg_data;
				pcc_pkg::REG_INT_LIM: regs_q.integral_limit    <= cfg_data[30:0];
				pcc_pkg::REG_DER_LIM: regs_q.derivative_limit  <= cfg_data[30:0];
				pcc_pkg::REG_OUT_LIM: regs_q.output_limit      <= cfg_data[30:0];
				pcc_pkg::REG_PERIOD:  regs_q.sample_period     <= cfg_data[16:0];
				pcc_pkg::REG_RATE:    regs_q.sample_rate       <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/pcc_mul.sv */
// Shared signed 33 by 33 multiplier with a registered product.
// Used by the sequencer in pid_controller_clamped; no package dependency.
`default_nettype none

module pcc_mul (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [32:0] a,
	input  wire logic signed [32:0] b,
	output logic signed [65:0]      prod_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

endmodule

`default_nettype wire

/* rtl/pid_controller_clamped.sv */
// Top level of the clamped PID controller: sequencer and datapath around
// one shared multiplier. Depends on pcc_pkg, pcc_cfg, pcc_mul and the defines header.
//
// Channel   Direction  Payload
// s_axis    in         tdata[31:0] setpoint, tdata[63:32] measurement
// m_axis    out        tdata[31:0] drive
// cfg       in         cfg_index register number, cfg_data value
//
// The drive takes five passes through the single multiplier plus the final sum
// and clamp; ST_FIN holds the drive back until m_axis is free, and the next tick
// is taken only after ST_FIN has handed the drive to the result register.
// A new tick is taken only when the sequencer is idle; the result register lets
// the next tick start while the previous drive still waits on m_axis.
// Reset clears integral, previous error and output valid; cfg registers take defaults.
`default_nettype none

`include "pid_controller_clamped_defines.svh"

module pid_controller_clamped (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // [31:0] setpoint, [63:32] measurement
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // [31:0] drive
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_M_INT = 7'b0000010,
		ST_M_DER = 7'b0000100,
		ST_M_P   = 7'b0001000,
		ST_M_I   = 7'b0010000,
		ST_M_D   = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	state_t             state_q;
	pcc_pkg::cfg_t      regs;
	logic signed [31:0] e_q;
	logic signed [31:0] prev_q;
	logic signed [32:0] diff_q;
	logic signed [31:0] integ_q;
	logic signed [31:0] deriv_q;
	logic signed [49:0] acc_q;
	logic [31:0]        drive_q;
	logic               out_valid_q;

	logic signed [32:0] err_wide;
	logic signed [31:0] err_sat;
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic               mul_en;
	logic signed [65:0] prod_q;
	logic signed [49:0] term;
	logic signed [57:0] int_sum;
	logic signed [49:0] out_sum;
	logic               out_free;
	logic               in_fire;

	pcc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	pcc_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = drive_q;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign err_wide = $signed({s_axis_tdata[31], s_axis_tdata[31:0]})
		- $signed({s_axis_tdata[63], s_axis_tdata[63:32]});

	always_comb begin
		if (err_wide[32] != err_wide[31]) begin
			err_sat = err_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			err_sat = err_wide[31:0];
		end
	end

	assign mul_en = (state_q == ST_M_INT) || (state_q == ST_M_DER) || (state_q == ST_M_P)
		|| (state_q == ST_M_I) || (state_q == ST_M_D);

	always_comb begin
		unique case (state_q)
			ST_M_INT: begin
				mul_a = {e_q[31], e_q};
				mul_b = {16'b0, regs.sample_period};
			end
			ST_M_DER: begin
				mul_a = diff_q;
				mul_b = {9'b0, regs.sample_rate};
			end
			ST_M_P: begin
				mul_a = {regs.gain_proportional[31], regs.gain_proportional};
				mul_b = {e_q[31], e_q};
			end
			ST_M_I: begin
				mul_a = {regs.gain_integral[31], regs.gain_integral};
				mul_b = {integ_q[31], integ_q};
			end
			ST_M_D: begin
				mul_a = {regs.gain_derivative[31], regs.gain_derivative};
				mul_b = {deriv_q[31], deriv_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Dropping 16 fraction bits of a two's complement product rounds toward minus infinity.
	assign term    = {{2{prod_q[63]}}, prod_q[63:16]};
	assign int_sum = $signed({{26{integ_q[31]}}, integ_q})
		+ $signed({{25{prod_q[48]}}, prod_q[48:16]});
	assign out_sum = acc_q + term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_q      <= '0;
			integ_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready && !((state_q == ST_FIN) && out_free)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_M_INT;
					end
				end
				ST_M_INT: begin
					prev_q  <= e_q;
					state_q <= ST_M_DER;
				end
				ST_M_DER: begin
					integ_q <= pcc_pkg::clamp_sym(int_sum, regs.integral_limit);
					state_q <= ST_M_P;
				end
				ST_M_P: begin
					state_q <= ST_M_I;
				end
				ST_M_I: begin
					state_q <= ST_M_D;
				end
				ST_M_D: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			e_q <= err_sat;
		end
		if (state_q == ST_M_INT) begin
			diff_q <= $signed({e_q[31], e_q}) - $signed({prev_q[31], prev_q});
		end
		if (state_q == ST_M_P) begin
			deriv_q <= pcc_pkg::clamp_sym(prod_q[57:0], regs.derivative_limit);
		end
		if (state_q == ST_M_I) begin
			acc_q <= term;
		end
		if (state_q == ST_M_D) begin
			acc_q <= out_sum;
		end
		if ((state_q == ST_FIN) && out_free) begin
			drive_q <= pcc_pkg::clamp_sym({{8{out_sum[49]}}, out_sum}, regs.output_limit);
		end
	end

	`PCC_ASSERT_NEXT(a_accept_starts, clk, arst_n, in_fire, state_q == ST_M_INT)
	`PCC_ASSERT_NOW(a_prev_updated, clk, arst_n, state_q == ST_M_DER, prev_q == e_q)
	`PCC_ASSERT_NEXT(a_fin_delivers, clk, arst_n, (state_q == ST_FIN) && out_free,
		m_axis_tvalid && (state_q == ST_IDLE))
	`PCC_ASSERT_NOW(a_drive_clamped, clk, arst_n, m_axis_tvalid,
		($signed(drive_q) <= $signed({1'b0, regs.output_limit}))
		&& ($signed(drive_q) >= -$signed({1'b0, regs.output_limit})))

endmodule

`default_nettype wire
